// ===== rtl/mhic_pkg.sv =====
package mhic_pkg;

   // request kinds
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   // register select, taken from paddr[2]
   localparam logic REG_CALIB_SECONDS = 1'b0;

   // tracker and offset reset values
   localparam logic signed [17:0] MAX_RESET   = -18'sd65536;
   localparam logic signed [17:0] MIN_RESET   = 18'sd65536;
   localparam logic signed [15:0] OFF_X_RESET = -16'sd217;
   localparam logic signed [15:0] OFF_Y_RESET = 16'sd105;
   localparam logic signed [15:0] OFF_Z_RESET = 16'sd60;

   localparam logic [15:0] TICKS_FULL = 16'hFFFF;

   typedef struct packed {
      logic clear;
      logic track;
      logic finish;
   } lane_cmd_type;

   typedef struct packed {
      logic signed [15:0] cor;
      logic signed [15:0] off;
   } lane_out_type;

   typedef struct packed {
      logic signed [15:0] cor_x;
      logic signed [15:0] cor_y;
      logic signed [15:0] cor_z;
      logic signed [15:0] off_x;
      logic signed [15:0] off_y;
      logic signed [15:0] off_z;
      logic               calibrating;
   } rsp_payload_type;

endpackage

// ===== rtl/mhic_if.sv =====
interface mhic_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] raw_x;
   logic signed [15:0] raw_y;
   logic signed [15:0] raw_z;

   modport source (output valid, kind, raw_x, raw_y, raw_z, input ready);
   modport sink   (input valid, kind, raw_x, raw_y, raw_z, output ready);
endinterface

interface mhic_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] cor_x;
   logic signed [15:0] cor_y;
   logic signed [15:0] cor_z;
   logic signed [15:0] off_x;
   logic signed [15:0] off_y;
   logic signed [15:0] off_z;
   logic               calibrating;

   modport source (output valid, cor_x, cor_y, cor_z, off_x, off_y, off_z, calibrating,
                   input ready);
   modport sink   (input valid, cor_x, cor_y, cor_z, off_x, off_y, off_z, calibrating,
                   output ready);
endinterface

// ===== rtl/mag_hard_iron_calibration.sv =====
// Three-axis magnetometer hard-iron corrector. Each request is a start
// command, a raw sample or a one-second tick; every request yields exactly
// one response carrying the corrected sample (raw minus offset, z negated
// first, wrapped to 16 bits), the three offsets and the calibrating flag.
// A start zeroes the offsets and runs calibration for calib_seconds ticks
// (register at byte address 0); the offsets then become the midpoint of
// the observed max and min per axis, rounded toward zero. One request is
// taken every clock cycle while the output stage has a free slot: the
// three axis lanes do their compare, midpoint and subtract combinationally,
// and the response is registered in a two-entry output stage, so one more
// request is taken into its second entry after the response side stalls.
module mag_hard_iron_calibration (
   input  logic        clock,
   input  logic        reset,
   mhic_req_if.sink    req_chan,
   mhic_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mhic_pkg::*;

   logic [15:0]  calib_ff;
   logic         fire;
   logic         push_ready;
   logic         calibrating;
   logic         calib_wr;
   lane_cmd_type cmd;
   lane_out_type lane_x, lane_y, lane_z;
   logic signed [15:0] neg_z;

   // Configuration port: zero-wait writes, word select on paddr[2]
   assign pready   = 1'b1;
   assign calib_wr = psel && penable && pwrite && (paddr[2] == REG_CALIB_SECONDS);
   assign prdata   = (paddr[2] == REG_CALIB_SECONDS) ? {16'd0, calib_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else if (calib_wr) begin
         calib_ff <= pwdata[15:0];
      end
   end

   // Accept a request whenever the output stage has a free slot
   assign req_chan.ready = push_ready;
   assign fire           = req_chan.valid && push_ready;

   // Negate z up front; the most negative code wraps onto itself
   assign neg_z = -req_chan.raw_z;

   // Sequencing: start, tick counting and end of calibration
   mhic_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .kind          (req_chan.kind),
      .calib_seconds (calib_ff),
      .cmd           (cmd),
      .calibrating   (calibrating)
   );

   // One lane per axis: trackers, offset and correction
   mhic_lane u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .raw      (req_chan.raw_x),
      .off_init (OFF_X_RESET),
      .result   (lane_x)
   );

   mhic_lane u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .raw      (req_chan.raw_y),
      .off_init (OFF_Y_RESET),
      .result   (lane_y)
   );

   mhic_lane u_lane_z (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .raw      (neg_z),
      .off_init (OFF_Z_RESET),
      .result   (lane_z)
   );

   // Combine the lanes into one response and hold it until taken
   mhic_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (fire),
      .lane_x      (lane_x),
      .lane_y      (lane_y),
      .lane_z      (lane_z),
      .calibrating (calibrating),
      .push_ready  (push_ready),
      .rsp         (rsp_chan)
   );

   // While calibrating, all offsets must read zero
   a_zero_offsets: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.calibrating |->
         rsp_chan.off_x == '0 && rsp_chan.off_y == '0 && rsp_chan.off_z == '0)
      else $error("nonzero offset reported during calibration");

   // Back-pressure only when both output entries are occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && $past(rsp_chan.valid))
      else $error("request side stalled with an empty output stage");

endmodule

// ===== rtl/mhic_lane.sv =====
module mhic_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  mhic_pkg::lane_cmd_type cmd,
   input  logic signed [15:0]    raw,
   input  logic signed [15:0]    off_init,
   output mhic_pkg::lane_out_type result
);
   import mhic_pkg::*;

   logic signed [17:0] max_ff, max_in, min_ff, min_in;
   logic signed [17:0] max_cur, min_cur, samp_wide;
   logic signed [15:0] off_ff, off_in, samp;
   logic signed [18:0] span_sum;
   logic [18:0]        adj_sum;

   always_comb begin
      samp      = raw - off_ff;
      samp_wide = 18'(samp);
      max_cur   = cmd.clear ? MAX_RESET : max_ff;
      min_cur   = cmd.clear ? MIN_RESET : min_ff;
      max_in    = max_cur;
      min_in    = min_cur;
      if (cmd.track) begin
         if (samp_wide > max_cur) max_in = samp_wide;
         if (samp_wide < min_cur) min_in = samp_wide;
      end
      // midpoint, rounded toward zero: add the sign bit before halving
      span_sum = 19'(max_cur) + 19'(min_cur);
      adj_sum  = span_sum + {18'd0, span_sum[18]};
      off_in   = off_ff;
      if (cmd.clear)  off_in = '0;
      if (cmd.finish) off_in = adj_sum[16:1];
      result.cor = raw - off_in;
      result.off = off_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_RESET;
         min_ff <= MIN_RESET;
         off_ff <= off_init;
      end else begin
         max_ff <= max_in;
         min_ff <= min_in;
         off_ff <= off_in;
      end
   end

endmodule

// ===== rtl/mhic_ctrl.sv =====
module mhic_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [1:0]             kind,
   input  logic [15:0]            calib_seconds,
   output mhic_pkg::lane_cmd_type cmd,
   output logic                   calibrating
);
   import mhic_pkg::*;

   logic        busy_ff, busy_in;
   logic [15:0] elapsed_ff, elapsed_in, ticks_next;

   always_comb begin
      cmd        = '0;
      busy_in    = busy_ff;
      elapsed_in = elapsed_ff;
      ticks_next = (elapsed_ff == TICKS_FULL) ? elapsed_ff : elapsed_ff + 16'd1;
      if (fire) begin
         case (kind)
            KIND_START: begin
               cmd.clear  = 1'b1;
               elapsed_in = '0;
               busy_in    = 1'b1;
               if (calib_seconds == '0) begin
                  cmd.finish = 1'b1;
                  busy_in    = 1'b0;
               end
            end
            KIND_SAMPLE: begin
               cmd.track = busy_ff;
            end
            KIND_TICK: begin
               if (busy_ff) begin
                  elapsed_in = ticks_next;
                  if (ticks_next >= calib_seconds) begin
                     cmd.finish = 1'b1;
                     busy_in    = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      calibrating = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         elapsed_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         elapsed_ff <= elapsed_in;
      end
   end

   a_zero_length: assert property (@(posedge clock) disable iff (reset)
      fire && kind == KIND_START && calib_seconds == '0 |=> !busy_ff)
      else $error("zero-length calibration left the block busy");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(fire && kind == KIND_START))
      else $error("calibration began without a start request");

endmodule

// ===== rtl/mhic_merge.sv =====
module mhic_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mhic_pkg::lane_out_type lane_x,
   input  mhic_pkg::lane_out_type lane_y,
   input  mhic_pkg::lane_out_type lane_z,
   input  logic                   calibrating,
   output logic                   push_ready,
   mhic_rsp_if.source             rsp
);
   import mhic_pkg::*;

   rsp_payload_type payload;
   rsp_payload_type main_ff, main_in, skid_ff, skid_in;
   logic            main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic            pop;

   always_comb begin
      payload.cor_x       = lane_x.cor;
      payload.cor_y       = lane_y.cor;
      payload.cor_z       = lane_z.cor;
      payload.off_x       = lane_x.off;
      payload.off_y       = lane_y.off;
      payload.off_z       = lane_z.off;
      payload.calibrating = calibrating;
   end

   assign pop        = main_valid_ff && rsp.ready;
   assign push_ready = !skid_valid_ff;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // drain the skid entry; no push can arrive while it is full
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = payload;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = payload;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid       = main_valid_ff;
   assign rsp.cor_x       = main_ff.cor_x;
   assign rsp.cor_y       = main_ff.cor_y;
   assign rsp.cor_z       = main_ff.cor_z;
   assign rsp.off_x       = main_ff.off_x;
   assign rsp.off_y       = main_ff.off_y;
   assign rsp.off_z       = main_ff.off_z;
   assign rsp.calibrating = main_ff.calibrating;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import mhic_pkg::*;

   // Kind value 3 has no meaning; the block must leave its state alone.
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // Byte address of calib_seconds: register select sits on paddr[2].
   localparam logic [2:0] ADDR_CALIB_SECONDS = {REG_CALIB_SECONDS, 2'b00};

   // Response-side stall patterns.
   localparam logic [1:0] RDY_OPEN    = 2'd0;
   localparam logic [1:0] RDY_COIN    = 2'd1;
   localparam logic [1:0] RDY_COMB    = 2'd2;
   localparam logic [1:0] RDY_TRICKLE = 2'd3;

   localparam int RANDOM_REQUESTS = 1650;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int REPORT_CAP      = 200;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
   } mag_req_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   mhic_req_if req_bus ();
   mhic_rsp_if rsp_bus ();

   mag_hard_iron_calibration u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the corrector: register, trackers, offsets, run state.
   // ---------------------------------------------------------------------
   logic [15:0]        calib_secs;
   logic signed [17:0] peak_hi [3];
   logic signed [17:0] peak_lo [3];
   logic signed [15:0] offset_q [3];
   logic               calib_run;
   logic [15:0]        tick_count;

   mag_req_type     pending_reqs [$];
   rsp_payload_type expected_rsp [$];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int queued_count   = 0;
   int burst_left     = 1;
   int gap_left       = 0;
   int stall_span     = 0;
   logic [1:0] stall_mode = RDY_OPEN;

   function automatic void clear_peaks();
      for (int i = 0; i < 3; i++) begin
         peak_hi[i] = MAX_RESET;
         peak_lo[i] = MIN_RESET;
      end
   endfunction

   function automatic void reset_shadow();
      calib_secs  = '0;
      clear_peaks();
      offset_q[0] = OFF_X_RESET;
      offset_q[1] = OFF_Y_RESET;
      offset_q[2] = OFF_Z_RESET;
      calib_run   = 1'b0;
      tick_count  = '0;
   endfunction

   // Offsets become the midpoint of each axis' span, rounded toward zero.
   function automatic void settle_offsets();
      int mid;
      for (int i = 0; i < 3; i++) begin
         mid         = (peak_hi[i] + peak_lo[i]) / 2;
         offset_q[i] = mid[15:0];
      end
      calib_run = 1'b0;
   endfunction

   // Advance the shadow state by one request and form its response.
   function automatic rsp_payload_type correct_sample(mag_req_type r);
      logic signed [15:0] lane_raw [3];
      logic signed [15:0] diff;
      logic signed [17:0] wide;
      rsp_payload_type    p;
      lane_raw[0] = r.raw_x;
      lane_raw[1] = r.raw_y;
      lane_raw[2] = -r.raw_z;   // wraps: -32768 stays -32768
      case (r.kind)
         KIND_START: begin
            for (int i = 0; i < 3; i++) offset_q[i] = '0;
            clear_peaks();
            calib_run  = 1'b1;
            tick_count = '0;
            if (calib_secs == 16'd0) settle_offsets();
         end
         KIND_SAMPLE: begin
            if (calib_run) begin
               for (int i = 0; i < 3; i++) begin
                  diff = lane_raw[i] - offset_q[i];
                  wide = diff;
                  if (wide > peak_hi[i]) peak_hi[i] = wide;
                  if (wide < peak_lo[i]) peak_lo[i] = wide;
               end
            end
         end
         KIND_TICK: begin
            if (calib_run) begin
               if (tick_count != TICKS_FULL) tick_count = tick_count + 16'd1;
               if (tick_count >= calib_secs) settle_offsets();
            end
         end
         default: ;   // spare kind: state untouched
      endcase
      p.cor_x       = lane_raw[0] - offset_q[0];
      p.cor_y       = lane_raw[1] - offset_q[1];
      p.cor_z       = lane_raw[2] - offset_q[2];
      p.off_x       = offset_q[0];
      p.off_y       = offset_q[1];
      p.off_z       = offset_q[2];
      p.calibrating = calib_run;
      return p;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_CAP)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps between them.
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 3) return 0;
      return $urandom_range(1, 8);
   endfunction

   always @(posedge clock) begin : drive_req
      mag_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.kind  <= KIND_TICK;
         req_bus.raw_x <= '0;
         req_bus.raw_y <= '0;
         req_bus.raw_z <= '0;
      end else if (!req_bus.valid || req_bus.ready) begin
         // Hold nothing here: the previous request is gone or never was.
         if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left      <= gap_left - 1;
         end else if (pending_reqs.size() > 0) begin
            nxt           = pending_reqs.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.kind  <= nxt.kind;
            req_bus.raw_x <= nxt.raw_x;
            req_bus.raw_y <= nxt.raw_y;
            req_bus.raw_z <= nxt.raw_z;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= pick_gap();
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response ready: switch at random among stall patterns.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= 2'($urandom_range(0, 3));
         stall_span <= $urandom_range(16, 80);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         RDY_OPEN:    rsp_bus.ready <= 1'b1;
         RDY_COIN:    rsp_bus.ready <= 1'($urandom_range(0, 1));
         RDY_COMB:    rsp_bus.ready <= (cycle_count % 5) >= 2;
         RDY_TRICKLE: rsp_bus.ready <= ($urandom_range(0, 9) == 0);
         default:     rsp_bus.ready <= 1'b1;
      endcase
   end

   // ---------------------------------------------------------------------
   // Monitor: predict each accepted request first, then check the response
   // taken at this edge against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      mag_req_type     seen;
      rsp_payload_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.kind  = req_bus.kind;
            seen.raw_x = req_bus.raw_x;
            seen.raw_y = req_bus.raw_y;
            seen.raw_z = req_bus.raw_z;
            expected_rsp.push_back(correct_sample(seen));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_CAP)
                  $error("response with no request outstanding");
            end else begin
               want = expected_rsp.pop_front();
               check_field("cor_x", want.cor_x, rsp_bus.cor_x);
               check_field("cor_y", want.cor_y, rsp_bus.cor_y);
               check_field("cor_z", want.cor_z, rsp_bus.cor_z);
               check_field("off_x", want.off_x, rsp_bus.off_x);
               check_field("off_y", want.off_y, rsp_bus.off_y);
               check_field("off_z", want.off_z, rsp_bus.off_z);
               check_field("calibrating", want.calibrating, rsp_bus.calibrating);
            end
         end
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   function automatic void queue_req(logic [1:0] kind, logic signed [15:0] x,
                                     logic signed [15:0] y, logic signed [15:0] z);
      mag_req_type r;
      r.kind  = kind;
      r.raw_x = x;
      r.raw_y = y;
      r.raw_z = z;
      pending_reqs.push_back(r);
      if (kind != KIND_SPARE) queued_count++;
   endfunction

   // Lean on the rails and on small values near typical offsets.
   function automatic logic signed [15:0] pick_raw();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($urandom_range(0, 600) - 300);
         3:       return 16'($urandom_range(0, 4000) - 2000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void queue_random(logic [1:0] kind);
      queue_req(kind, pick_raw(), pick_raw(), pick_raw());
   endfunction

   // Pause until every request has been taken and answered.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || expected_rsp.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   // Two-phase register write; junk in the upper bits must be ignored.
   task automatic write_calib(input logic [15:0] secs);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_CALIB_SECONDS;
      pwdata  <= {16'($urandom), secs};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel       <= 1'b0;
      penable    <= 1'b0;
      pwrite     <= 1'b0;
      calib_secs = secs;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int          roll;
      int          goal;
      int          ticks_done;
      int          tail;
      logic [15:0] secs;
      logic [15:0] retarget;
      bit          dry;

      reset_shadow();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset offsets in force; z of -32768 negates onto itself.
      queue_req(KIND_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh8000);
      queue_req(KIND_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
      // Tick while idle and the spare kind: both leave the state alone.
      queue_req(KIND_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
      queue_req(KIND_SPARE, 16'shFFFF, 16'shFFFF, 16'shFFFF);
      // Zero duration: a start finishes at once with all offsets zero.
      queue_req(KIND_START, 16'sd1234, -16'sd77, 16'sd9);
      queue_req(KIND_SAMPLE, 16'sd5, 16'sd5, 16'sd5);
      wait_idle();

      // Three seconds with no samples: offsets settle at zero.
      write_calib(16'd3);
      queue_req(KIND_START, 16'sd0, 16'sd0, 16'sd0);
      repeat (3) queue_req(KIND_TICK, 16'sd1, 16'sd2, 16'sd3);
      // Rail samples, then restart in mid run.
      queue_req(KIND_START, 16'sd0, 16'sd0, 16'sd0);
      queue_req(KIND_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      queue_req(KIND_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8001);
      queue_req(KIND_TICK, 16'sd0, 16'sd0, 16'sd0);
      queue_req(KIND_START, 16'sd0, 16'sd0, 16'sd0);
      // Odd negative sum on x: the midpoint must round toward zero.
      queue_req(KIND_SAMPLE, 16'sd100, 16'sd7, 16'sd10);
      queue_req(KIND_SAMPLE, -16'sd103, 16'sd2, 16'sd20);
      repeat (3) queue_req(KIND_TICK, 16'sd0, 16'sd0, 16'sd0);
      wait_idle();

      // Longest duration, then shorten it under a running calibration.
      write_calib(16'hFFFF);
      queue_req(KIND_START, 16'sd0, 16'sd0, 16'sd0);
      queue_req(KIND_SAMPLE, 16'sd321, -16'sd45, 16'sd600);
      queue_req(KIND_TICK, 16'sd0, 16'sd0, 16'sd0);
      wait_idle();
      write_calib(16'd1);
      queue_req(KIND_TICK, 16'sd0, 16'sd0, 16'sd0);
      queue_req(KIND_SAMPLE, 16'sd321, -16'sd45, 16'sd600);

      // Random calibrations: mostly short well-formed runs with noise.
      queued_count = 0;
      while (queued_count < RANDOM_REQUESTS) begin
         roll = $urandom_range(0, 99);
         if (roll < 10)      secs = 16'd0;
         else if (roll < 75) secs = 16'($urandom_range(1, 6));
         else if (roll < 92) secs = 16'($urandom_range(7, 40));
         else                secs = 16'hFFFF;
         wait_idle();
         write_calib(secs);

         dry        = ($urandom_range(0, 9) == 0);
         goal       = (secs == 16'hFFFF) ? $urandom_range(1, 4) : int'(secs);
         ticks_done = 0;
         queue_random(KIND_START);
         while (ticks_done < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 60 && !dry) begin
               queue_random(KIND_SAMPLE);
            end else if (roll < 93) begin
               queue_random(KIND_TICK);
               ticks_done++;
            end else if (roll < 98) begin
               queue_random(KIND_SPARE);
            end else begin
               queue_random(KIND_START);
               ticks_done = 0;
            end
         end

         // Cut the long run short while it is still going.
         if (secs == 16'hFFFF) begin
            wait_idle();
            retarget = 16'($urandom_range(1, 6));
            write_calib(retarget);
            goal = (retarget > ticks_done) ? int'(retarget) - ticks_done : 1;
            repeat ($urandom_range(0, 4)) queue_random(KIND_SAMPLE);
            repeat (goal) queue_random(KIND_TICK);
         end

         // Tail after the run: corrected samples, stray ticks, spare kind, restarts.
         tail = $urandom_range(0, 6);
         repeat (tail) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)      queue_random(KIND_SAMPLE);
            else if (roll < 80) queue_random(KIND_TICK);
            else if (roll < 95) queue_random(KIND_SPARE);
            else                queue_random(KIND_START);
         end
      end

      // Drain, then let the output stage settle.
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || expected_rsp.size() != 0);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mhic_pkg.sv
rtl/mhic_if.sv
rtl/mhic_lane.sv
rtl/mhic_ctrl.sv
rtl/mhic_merge.sv
rtl/mag_hard_iron_calibration.sv
bench/testbench.sv
